### src/tslnf_pkg.sv
// Shared types and constants for the line numbering text filter.
package tslnf_pkg;

   localparam int NumDigits = 6;                  // width of the line number field
   localparam int MaxOut    = 12;                 // buffer depth in beats; one input beat yields at most 11
   localparam int TextMax   = 4;                  // most beats from the text byte itself
   localparam int CountW    = $clog2(MaxOut + 1);
   localparam int TextCntW  = $clog2(TextMax + 1);
   localparam int CsrIdxW   = 3;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrNumberAll      = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrNumberNonblank = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrSqueezeBlank   = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrShowLineEnds   = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrShowTabs       = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrShowNonprint   = 3'd5;

   // characters
   localparam logic [7:0] ChTab      = 8'h09;
   localparam logic [7:0] ChNewline  = 8'h0A;
   localparam logic [7:0] ChSpace    = 8'h20;
   localparam logic [7:0] ChDollar   = 8'h24;
   localparam logic [7:0] ChDash     = 8'h2D;
   localparam logic [7:0] ChQuestion = 8'h3F;
   localparam logic [7:0] ChUpperI   = 8'h49;
   localparam logic [7:0] ChUpperM   = 8'h4D;
   localparam logic [7:0] ChCaret    = 8'h5E;
   localparam logic [7:0] ChDelete   = 8'h7F;
   localparam logic [7:0] PrintLow   = 8'd32;
   localparam logic [7:0] PrintHigh  = 8'd126;
   localparam logic [6:0] CaretShift = 7'd64;
   localparam logic [3:0] DigitHigh  = 4'd9;
   localparam logic [3:0] AsciiDigit = 4'h3;
   localparam logic [1:0] BlankSat   = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic number_all_lines;
      logic number_nonblank_lines;
      logic squeeze_blank_lines;
      logic show_line_ends;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

   typedef struct packed {
      logic                          last_was_newline;
      logic [1:0]                    blank_run;
      logic [NumDigits-1:0][3:0]     digits;     // digit 0 is the least significant
   } line_state_type;

   typedef struct packed {
      logic [MaxOut-1:0][7:0] bytes;             // bytes[0] goes out first
      logic [CountW-1:0]      len;
   } job_type;

endpackage

### src/tslnf_format.sv
// Expands one input byte into its output bytes and computes the next line state.
module tslnf_format import tslnf_pkg::*; (
   input  req_payload_type req_payload,
   input  cfg_type         cfg,
   input  line_state_type  state,
   output line_state_type  state_next,
   output job_type         job
);

   logic [7:0]               c;
   logic                     is_nl;
   logic                     line_start;
   logic [1:0]               blank_run0;
   logic [1:0]               blank_run1;
   logic                     skip;
   logic                     put_num;
   logic                     all_nines;
   logic                     carry;
   logic                     lead;
   logic [NumDigits-1:0][3:0] digits_inc;
   logic [TextMax-1:0][7:0]  t_bytes;
   logic [TextCntW-1:0]      t_len;
   logic [6:0]               lo;

   assign c          = req_payload.data_byte;
   assign is_nl      = (c == ChNewline);
   assign line_start = req_payload.file_start || state.last_was_newline;

   // blank-run tracking; cleared at a file start, saturating
   always_comb begin
      blank_run0 = req_payload.file_start ? 2'd0 : state.blank_run;
      blank_run1 = blank_run0;
      if (line_start) begin
         if (is_nl) begin
            blank_run1 = (blank_run0 == BlankSat) ? BlankSat : blank_run0 + 2'd1;
         end else begin
            blank_run1 = 2'd0;
         end
      end
   end

   assign skip = cfg.squeeze_blank_lines && line_start && is_nl && (blank_run1 > 2'd1);

   assign put_num = state.last_was_newline &&
                    (cfg.number_nonblank_lines ? !is_nl : cfg.number_all_lines);

   // saturating decimal increment
   always_comb begin
      all_nines = 1'b1;
      for (int i = 0; i < NumDigits; i++) begin
         if (state.digits[i] != DigitHigh) all_nines = 1'b0;
      end
      digits_inc = state.digits;
      carry      = !all_nines;
      for (int i = 0; i < NumDigits; i++) begin
         if (carry) begin
            if (state.digits[i] < DigitHigh) begin
               digits_inc[i] = state.digits[i] + 4'd1;
               carry         = 1'b0;
            end else begin
               digits_inc[i] = 4'd0;
            end
         end
      end
   end

   // text part: '$', caret and M- notation; at most four beats, so the
   // write index never reaches four
   always_comb begin
      t_bytes = '0;
      t_len   = '0;
      lo      = c[6:0];
      if (cfg.show_line_ends && is_nl) begin
         t_bytes[t_len[1:0]] = ChDollar;
         t_len               = t_len + TextCntW'(1);
      end
      if (cfg.show_nonprinting && (c < PrintLow || c > PrintHigh)) begin
         if ((c == ChTab && !cfg.show_tabs) || is_nl) begin
            t_bytes[t_len[1:0]] = c;
            t_len               = t_len + TextCntW'(1);
         end else if (c == ChDelete) begin
            t_bytes[t_len[1:0]] = ChCaret;
            t_len               = t_len + TextCntW'(1);
            t_bytes[t_len[1:0]] = ChQuestion;
            t_len               = t_len + TextCntW'(1);
         end else begin
            if (c[7]) begin
               t_bytes[t_len[1:0]] = ChUpperM;
               t_len               = t_len + TextCntW'(1);
               t_bytes[t_len[1:0]] = ChDash;
               t_len               = t_len + TextCntW'(1);
            end
            if (lo < PrintLow[6:0]) begin
               t_bytes[t_len[1:0]] = ChCaret;
               t_len               = t_len + TextCntW'(1);
               lo                  = lo + CaretShift;
            end
            // a high delete falls through here and goes out raw
            t_bytes[t_len[1:0]] = {1'b0, lo};
            t_len               = t_len + TextCntW'(1);
         end
      end else if (cfg.show_tabs && c == ChTab) begin
         t_bytes[t_len[1:0]] = ChCaret;
         t_len               = t_len + TextCntW'(1);
         t_bytes[t_len[1:0]] = ChUpperI;
         t_len               = t_len + TextCntW'(1);
      end else begin
         t_bytes[t_len[1:0]] = c;
         t_len               = t_len + TextCntW'(1);
      end
   end

   // assemble the beat list: optional number and tab, then the text part
   always_comb begin
      job.bytes = '0;
      lead      = 1'b1;
      if (put_num) begin
         for (int k = NumDigits - 1; k >= 0; k--) begin
            if (digits_inc[k] != 4'd0 || k == 0) lead = 1'b0;
            job.bytes[NumDigits-1-k] = lead ? ChSpace : {AsciiDigit, digits_inc[k]};
         end
         job.bytes[NumDigits] = ChTab;
         for (int j = 0; j < TextMax; j++) begin
            job.bytes[NumDigits+1+j] = t_bytes[j];
         end
      end else begin
         for (int j = 0; j < TextMax; j++) begin
            job.bytes[j] = t_bytes[j];
         end
      end
      if (skip) begin
         job.len = '0;
      end else if (put_num) begin
         job.len = CountW'(NumDigits + 1) + CountW'(t_len);
      end else begin
         job.len = CountW'(t_len);
      end
   end

   always_comb begin
      state_next           = state;
      state_next.blank_run = blank_run1;
      if (!skip) begin
         state_next.last_was_newline = is_nl;
         if (put_num) state_next.digits = digits_inc;
      end
   end

endmodule

### src/tslnf_emit.sv
// Beat buffer for one expanded input byte and the registered result stage.
module tslnf_emit import tslnf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  job_type         job,
   output logic            can_load,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [MaxOut-1:0][7:0] buf_ff, buf_in;
   logic [CountW-1:0]      left_ff, left_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_payload_type        out_ff, out_in;
   logic                   move;

   // a beat moves into the result register whenever that register is free or draining
   assign move     = (left_ff != '0) && (!out_valid_ff || rsp_ready);
   assign can_load = (left_ff == '0) || ((left_ff == CountW'(1)) && move);

   always_comb begin
      buf_in       = buf_ff;
      left_in      = left_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (move) begin
         out_valid_in       = 1'b1;
         out_in.out_byte    = buf_ff[0];
         out_in.last_of_run = (left_ff == CountW'(1));
         for (int i = 0; i < MaxOut - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         buf_in[MaxOut-1] = '0;
         left_in          = left_ff - CountW'(1);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         buf_in  = job.bytes;
         left_in = job.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
      buf_ff <= buf_in;
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

### src/text_stream_line_numbering_filter_core.sv
// Top level of the line numbering, squeezing and show-nonprinting text filter.
//
//  channel | ports                              | beat
//  --------+------------------------------------+----------------------------------
//  req     | req_valid req_ready req_payload    | data_byte, file_start
//  rsp     | rsp_valid rsp_ready rsp_payload    | out_byte, last_of_run
//  csr     | csr_we csr_index csr_wdata         | one 1-bit register per write
//
//  An input beat is expanded in the accept cycle into 0 to 11 output beats held in a
//  shift buffer; the single result register drains the buffer, sending one beat per
//  cycle while rsp_ready is high.
//  The next input beat is taken in the cycle the last buffered beat moves out.
//  A stalled rsp_ready holds the buffer and in turn req_ready.
//  Synchronous reset clears registers, line state (counter zero, at line start) and queues.
module text_stream_line_numbering_filter_core import tslnf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic                csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   line_state_type state_ff, state_next;
   job_type        job;
   logic           accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CsrNumberAll:      cfg_in.number_all_lines      = csr_wdata;
            CsrNumberNonblank: cfg_in.number_nonblank_lines = csr_wdata;
            CsrSqueezeBlank:   cfg_in.squeeze_blank_lines   = csr_wdata;
            CsrShowLineEnds:   cfg_in.show_line_ends        = csr_wdata;
            CsrShowTabs:       cfg_in.show_tabs             = csr_wdata;
            CsrShowNonprint:   cfg_in.show_nonprinting      = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                    <= '0;
         state_ff.last_was_newline <= 1'b1;
         state_ff.blank_run        <= '0;
         state_ff.digits           <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) state_ff <= state_next;
      end
   end

   tslnf_format u_format (
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .state       (state_ff),
      .state_next  (state_next),
      .job         (job)
   );

   tslnf_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .job         (job),
      .can_load    (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
